// ===== src/cswq_pkg.sv =====
// ----------------------------------------------------------------------------
// cswq_pkg
// Shared types and codes of the counting semaphore wait queue core.
// ----------------------------------------------------------------------------
`default_nettype none

package cswq_pkg;

   // request kinds
   localparam logic [1:0] OP_TRY_WAIT = 2'd0;
   localparam logic [1:0] OP_WAIT     = 2'd1;
   localparam logic [1:0] OP_SIGNAL   = 2'd2;

   // result status codes
   localparam logic [2:0] ST_ACQUIRED    = 3'd0;
   localparam logic [2:0] ST_BLOCKED     = 3'd1;
   localparam logic [2:0] ST_WOULD_BLOCK = 3'd2;
   localparam logic [2:0] ST_SIGNALED    = 3'd3;
   localparam logic [2:0] ST_QUEUE_FULL  = 3'd4;
   localparam logic [2:0] ST_COUNT_SAT   = 3'd5;

   localparam logic signed [15:0] COUNT_MAX = 16'sd32767;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] thread_id;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               woken_valid;
      logic [7:0]         woken_thread;
      logic signed [15:0] count_after;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/counting_semaphore_wait_queue_core.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_core
// Counting semaphore with a FIFO of blocked thread ids.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per request (try-wait, blocking wait, signal)
//            carrying the op code and the requesting thread id.
//   rsp_*  : one transaction per request with status, woken thread and the
//            count after the request, in request order.
//   csr_*  : write of initial_count; reloads the count and empties the
//            waiter queue. Write only while no request is in flight.
// Timing: a request is accepted in the idle state, which also starts the read of
//   the head waiter from the waiter memory; execute uses the registered read data
//   and loads the response register once it is free. A new request is taken only
//   after the last one leaves execute, so requests do not overlap; rsp_valid is
//   registered and rises after execute loads the response register.
// Stall: the response register holds while rsp_ready is low; one further
//   request may be accepted and then waits in execute until it frees up.
// Reset: count loads 0 (initial_count resets to 0), queue empty, no response.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_wait_queue_core #(
   parameter int WAITER_DEPTH   = 16,
   parameter int THREAD_ID_BITS = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cswq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cswq_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [14:0]      csr_data
);

   localparam int PTR_W = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
   localparam int OCC_W = $clog2(WAITER_DEPTH + 1);
   localparam int ID_W  = THREAD_ID_BITS;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                state_ff, state_in;
   cswq_pkg::req_type   req_ff;
   logic signed [15:0]  count_ff, count_in;
   logic [PTR_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic                rsp_valid_ff;
   cswq_pkg::rsp_type   rsp_ff, rsp_in;

   logic                accept, commit, csr_fire, push;
   logic [ID_W-1:0]     wr_id, rd_id;
   logic [ID_W+7:0]     id_in_ext, id_out_ext;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // resize thread ids between the 8-bit port and the stored width
   assign id_in_ext  = {{ID_W{1'b0}}, req_ff.thread_id};
   assign wr_id      = id_in_ext[ID_W-1:0];
   assign id_out_ext = {8'd0, rd_id};

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(WAITER_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      occ_in   = occ_ff;
      push     = 1'b0;
      rsp_in.status       = cswq_pkg::ST_WOULD_BLOCK;
      rsp_in.woken_valid  = 1'b0;
      rsp_in.woken_thread = 8'd0;
      unique case (req_ff.op)
         cswq_pkg::OP_TRY_WAIT: begin
            if (count_ff > 16'sd0) begin
               count_in      = count_ff - 16'sd1;
               rsp_in.status = cswq_pkg::ST_ACQUIRED;
            end
         end
         cswq_pkg::OP_WAIT: begin
            if (count_ff > 16'sd0) begin
               count_in      = count_ff - 16'sd1;
               rsp_in.status = cswq_pkg::ST_ACQUIRED;
            end else if (occ_ff >= OCC_W'(WAITER_DEPTH)) begin
               rsp_in.status = cswq_pkg::ST_QUEUE_FULL;
            end else begin
               count_in      = count_ff - 16'sd1;
               push          = 1'b1;
               tail_in       = next_ptr(tail_ff);
               occ_in        = occ_ff + OCC_W'(1);
               rsp_in.status = cswq_pkg::ST_BLOCKED;
            end
         end
         cswq_pkg::OP_SIGNAL: begin
            if (count_ff >= cswq_pkg::COUNT_MAX) begin
               rsp_in.status = cswq_pkg::ST_COUNT_SAT;
            end else begin
               if ((count_ff < 16'sd0) && (occ_ff != '0)) begin
                  rsp_in.woken_valid  = 1'b1;
                  rsp_in.woken_thread = id_out_ext[7:0];
                  head_in             = next_ptr(head_ff);
                  occ_in              = occ_ff - OCC_W'(1);
               end
               count_in      = count_ff + 16'sd1;
               rsp_in.status = cswq_pkg::ST_SIGNALED;
            end
         end
         default: begin
            // unused op code: report would_block, change nothing
         end
      endcase
      rsp_in.count_after = count_in;
   end

   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = ST_EXEC;
      end else if (commit) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 16'sd0;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_fire) begin
            // reload the count and drop all waiters
            count_ff <= signed'({1'b0, csr_data});
            head_ff  <= '0;
            tail_ff  <= '0;
            occ_ff   <= '0;
         end else if (commit) begin
            count_ff <= count_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            occ_ff   <= occ_in;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // read the head waiter as the request is taken; data is ready in execute
   cswq_waiter_ram #(
      .DEPTH  (WAITER_DEPTH),
      .WIDTH  (ID_W),
      .ADDR_W (PTR_W)
   ) u_waiter_ram (
      .clock   (clock),
      .wr_en   (commit && push),
      .wr_addr (tail_ff),
      .wr_data (wr_id),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (rd_id)
   );

`ifndef NO_ASSERTIONS
   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(WAITER_DEPTH))
      else $error("waiter occupancy exceeds depth");

   a_occ_tracks_count : assert property (@(posedge clock) disable iff (reset)
      (count_ff < 16'sd0) ? ($unsigned(-count_ff) == 16'(occ_ff)) : (occ_ff == '0))
      else $error("occupancy does not match negative count");

   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not enter execute");

   a_woken_signal : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.woken_valid) |-> (rsp_ff.status == cswq_pkg::ST_SIGNALED))
      else $error("woken thread reported without signal status");
`endif

endmodule

`default_nettype wire

// ===== src/cswq_waiter_ram.sv =====
// ----------------------------------------------------------------------------
// cswq_waiter_ram
// Waiter id storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cswq_waiter_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire
